FILE: sv/tpr_pkg.sv
// Shared types and constants for the accelerometer tilt (pitch/roll) pipeline.
// Used by tpr_isqrt, tpr_cordic and accel_tilt_pitch_roll; no dependencies.
package tpr_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int ANGLE_W  = 16;

  // Square-root stage geometry: operand is (b^2 + c^2) << SQ_SHIFT
  localparam int SQ_W     = 32;
  localparam int SQ_SHIFT = 30;
  localparam int ROOT_W   = 31;
  localparam int REM_W    = 34;

  // CORDIC geometry, angles in units of 2^-30 rad
  localparam int CORDIC_STEPS   = 30;
  localparam int INT_ANGLE_BITS = 30;
  localparam int XY_W           = 35;
  localparam int ANG_W          = 33;
  localparam int VAL_W          = 35;

  localparam int DEF_ANGLE_FRAC_BITS = 13;

  localparam logic [VAL_W-1:0] PI30    = 35'd3373259426;
  localparam logic [VAL_W-1:0] TWOPI30 = 35'd6746518852;

  // atan(2^-i) in units of 2^-30 rad, rounded half up
  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
    33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
    33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
    33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
    33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
    33'sd1024,      33'sd512,       33'sd256,       33'sd128,
    33'sd64,        33'sd32,        33'sd16,        33'sd8,
    33'sd4,         33'sd2
  };

  // Sideband that rides alongside an item
  typedef struct packed {
    logic degen;   // all three axes zero
    logic upper;   // z >= 0, or x and y both zero
  } side_t;

endpackage

FILE: sv/tpr_isqrt.sv
// Pipelined integer square root of (sq << 30), one root bit per stage.
// Depends on tpr_pkg. Carries the CORDIC numerator and sideband alongside.
module tpr_isqrt (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic [tpr_pkg::SQ_W-1:0]            in_sq,
  input  logic signed [tpr_pkg::SAMPLE_W-1:0] in_num,
  input  tpr_pkg::side_t                      in_side,
  output logic                                out_vld,
  output logic [tpr_pkg::ROOT_W-1:0]          out_root,
  output logic signed [tpr_pkg::SAMPLE_W-1:0] out_num,
  output tpr_pkg::side_t                      out_side
);

  localparam int NST = tpr_pkg::ROOT_W;

  logic                                vld_r  [NST];
  logic [tpr_pkg::SQ_W-1:0]            sq_r   [NST];
  logic [tpr_pkg::REM_W-1:0]           rem_r  [NST];
  logic [tpr_pkg::ROOT_W-1:0]          root_r [NST];
  logic signed [tpr_pkg::SAMPLE_W-1:0] num_r  [NST];
  tpr_pkg::side_t                      side_r [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    localparam int J = NST - 1 - k;  // root bit resolved here

    logic                                vld_in;
    logic [tpr_pkg::SQ_W-1:0]            sq_in;
    logic [tpr_pkg::REM_W-1:0]           rem_in;
    logic [tpr_pkg::ROOT_W-1:0]          root_in;
    logic signed [tpr_pkg::SAMPLE_W-1:0] num_in;
    tpr_pkg::side_t                      side_in;
    logic [1:0]                          dig;
    logic [tpr_pkg::REM_W-1:0]           rem_sh;
    logic [tpr_pkg::REM_W-1:0]           trial;
    logic                                ge;

    if (k == 0) begin : g_src0
      assign vld_in  = in_vld;
      assign sq_in   = in_sq;
      assign rem_in  = '0;
      assign root_in = '0;
      assign num_in  = in_num;
      assign side_in = in_side;
    end else begin : g_srcn
      assign vld_in  = vld_r[k-1];
      assign sq_in   = sq_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign num_in  = num_r[k-1];
      assign side_in = side_r[k-1];
    end

    // next operand digit pair; the low SQ_SHIFT bits of the operand are zero
    if (2 * J >= tpr_pkg::SQ_SHIFT) begin : g_dig
      assign dig = sq_in[2*J-tpr_pkg::SQ_SHIFT+1 -: 2];
    end else begin : g_zero
      assign dig = 2'b00;
    end

    // trial subtract of (root << 2) | 1
    assign rem_sh = {rem_in[tpr_pkg::REM_W-3:0], dig};
    assign trial  = {{(tpr_pkg::REM_W-tpr_pkg::ROOT_W-2){1'b0}}, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k]   <= sq_in;
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {root_in[tpr_pkg::ROOT_W-2:0], ge};
        num_r[k]  <= num_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign out_root = root_r[NST-1];
  assign out_num  = num_r[NST-1];
  assign out_side = side_r[NST-1];

endmodule

FILE: sv/tpr_cordic.sv
// Pipelined vectoring CORDIC: atan2(num, root) in units of 2^-30 rad.
// Depends on tpr_pkg (arctangent table). One iteration per stage.
module tpr_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic [tpr_pkg::ROOT_W-1:0]          in_root,
  input  logic signed [tpr_pkg::SAMPLE_W-1:0] in_num,
  input  tpr_pkg::side_t                      in_side,
  output logic                                out_vld,
  output logic signed [tpr_pkg::ANG_W-1:0]    out_ang,
  output tpr_pkg::side_t                      out_side
);

  localparam int NST = tpr_pkg::CORDIC_STEPS;
  localparam int XW  = tpr_pkg::XY_W;

  logic                             vld_r  [NST];
  logic signed [XW-1:0]             x_r    [NST];
  logic signed [XW-1:0]             y_r    [NST];
  logic signed [tpr_pkg::ANG_W-1:0] ang_r  [NST];
  tpr_pkg::side_t                   side_r [NST];

  for (genvar i = 0; i < NST; i++) begin : g_st
    logic                             vld_in;
    logic signed [XW-1:0]             x_in;
    logic signed [XW-1:0]             y_in;
    logic signed [tpr_pkg::ANG_W-1:0] ang_in;
    tpr_pkg::side_t                   side_in;
    logic signed [XW-1:0]             dx;
    logic signed [XW-1:0]             dy;

    if (i == 0) begin : g_src0
      assign vld_in  = in_vld;
      assign x_in    = $signed({{(XW-tpr_pkg::ROOT_W){1'b0}}, in_root});
      assign y_in    = $signed({{(XW-tpr_pkg::SAMPLE_W-15){in_num[tpr_pkg::SAMPLE_W-1]}},
                                in_num, 15'b0});
      assign ang_in  = '0;
      assign side_in = in_side;
    end else begin : g_srcn
      assign vld_in  = vld_r[i-1];
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign ang_in  = ang_r[i-1];
      assign side_in = side_r[i-1];
    end

    // floor shifts
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    // rotate toward y = 0
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_in;
        if (!y_in[XW-1]) begin
          x_r[i]   <= x_in + dx;
          y_r[i]   <= y_in - dy;
          ang_r[i] <= ang_in + tpr_pkg::ATAN_TAB[i];
        end else begin
          x_r[i]   <= x_in - dx;
          y_r[i]   <= y_in + dy;
          ang_r[i] <= ang_in - tpr_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign out_ang  = ang_r[NST-1];
  assign out_side = side_r[NST-1];

endmodule

FILE: sv/accel_tilt_pitch_roll.sv
// Accelerometer tilt: pitch and roll from one x/y/z sample per item.
// Pipeline: 1 square stage, 31 square-root stages, 30 CORDIC stages,
// 2 angle/quantize stages (the last is the output register). Throughput one
// item per cycle; the whole pipeline holds while the output item waits.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
// Depends on tpr_pkg, tpr_isqrt, tpr_cordic.
module accel_tilt_pitch_roll #(
  parameter int ANGLE_FRAC_BITS = tpr_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pitch_angle [15:0], roll_angle [31:16]
  output logic        out_tuser   // degenerate [0]
);

  localparam int SH  = tpr_pkg::INT_ANGLE_BITS - ANGLE_FRAC_BITS;
  localparam int VW  = tpr_pkg::VAL_W;
  localparam int AW  = tpr_pkg::ANGLE_W;
  localparam int SW  = tpr_pkg::SAMPLE_W;
  localparam logic [VW-1:0] HALF = VW'(1) << (SH - 1);
  localparam logic [VW-1:0] MODV = (tpr_pkg::TWOPI30 + HALF) >> SH;

  logic adv;

  logic signed [SW-1:0] ax, ay, az;

  // stage 0: squares
  logic                      s0_vld_r;
  logic [tpr_pkg::SQ_W-1:0]  s0_sqx_r, s0_sqy_r;
  logic signed [SW-1:0]      s0_x_r, s0_y_r;
  tpr_pkg::side_t            s0_side_r;
  logic signed [2*SW-1:0]    px, py, pz;

  logic                              qx_vld, qy_vld;
  logic [tpr_pkg::ROOT_W-1:0]        qx_root, qy_root;
  logic signed [SW-1:0]              qx_num, qy_num;
  tpr_pkg::side_t                    qx_side, qy_side;
  logic                              cx_vld, cy_vld;
  logic signed [tpr_pkg::ANG_W-1:0]  cx_ang, cy_ang;
  tpr_pkg::side_t                    cx_side, cy_side;

  // angle stage
  logic                 a_vld_r, a_degen_r;
  logic signed [VW-1:0] a_pitch_r, a_roll_r;
  logic signed [VW-1:0] xa_ext, ya_ext, pitch_nxt, roll_nxt;

  // output stage
  logic          o_vld_r, o_degen_r;
  logic [AW-1:0] o_pitch_r, o_roll_r;
  logic [AW-1:0] pitch_q, roll_q;

  // pipeline moves whenever the output register is free or being taken
  assign adv       = !o_vld_r || out_tready;
  assign in_tready = adv;

  assign ax = $signed(in_tdata[15:0]);
  assign ay = $signed(in_tdata[31:16]);
  assign az = $signed(in_tdata[47:32]);
  assign px = ax * ax;
  assign py = ay * ay;
  assign pz = az * az;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_tvalid;
    end
  end

  // squared magnitudes across each angle's horizontal plane
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sqx_r        <= $unsigned(py) + $unsigned(pz);
      s0_sqy_r        <= $unsigned(px) + $unsigned(pz);
      s0_x_r          <= ax;
      s0_y_r          <= ay;
      s0_side_r.degen <= (ax == '0) && (ay == '0) && (az == '0);
      s0_side_r.upper <= !az[SW-1] || ((ax == '0) && (ay == '0));
    end
  end

  // both lanes carry the same sideband
  tpr_isqrt u_sqrt_x (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(s0_vld_r), .in_sq(s0_sqx_r), .in_num(s0_x_r), .in_side(s0_side_r),
    .out_vld(qx_vld), .out_root(qx_root), .out_num(qx_num), .out_side(qx_side)
  );

  tpr_isqrt u_sqrt_y (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(s0_vld_r), .in_sq(s0_sqy_r), .in_num(s0_y_r), .in_side(s0_side_r),
    .out_vld(qy_vld), .out_root(qy_root), .out_num(qy_num), .out_side(qy_side)
  );

  tpr_cordic u_cordic_x (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(qx_vld), .in_root(qx_root), .in_num(qx_num), .in_side(qx_side),
    .out_vld(cx_vld), .out_ang(cx_ang), .out_side(cx_side)
  );

  tpr_cordic u_cordic_y (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(qy_vld), .in_root(qy_root), .in_num(qy_num), .in_side(qy_side),
    .out_vld(cy_vld), .out_ang(cy_ang), .out_side(cy_side)
  );

  // branch to full-turn angle
  assign xa_ext = VW'(cx_ang);
  assign ya_ext = VW'(cy_ang);

  always_comb begin
    if (cx_side.upper) begin
      pitch_nxt = xa_ext[VW-1] ? xa_ext + $signed(tpr_pkg::TWOPI30) : xa_ext;
    end else begin
      pitch_nxt = $signed(tpr_pkg::PI30) - xa_ext;
    end
    if (cy_side.upper) begin
      roll_nxt  = ya_ext[VW-1] ? ya_ext + $signed(tpr_pkg::TWOPI30) : ya_ext;
    end else begin
      roll_nxt  = $signed(tpr_pkg::PI30) - ya_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= cx_vld && cy_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pitch_r <= pitch_nxt;
      a_roll_r  <= roll_nxt;
      a_degen_r <= cx_side.degen && cy_side.degen;
    end
  end

  // clamp negatives to zero, round half up, then fold a full turn back to zero
  function automatic logic [AW-1:0] quant(input logic signed [VW-1:0] v);
    logic [VW-1:0] c;
    logic [VW-1:0] q;
    logic [VW-1:0] m;
    c = v[VW-1] ? '0 : $unsigned(v);
    q = (c + HALF) >> SH;
    m = (q >= MODV) ? (q - MODV) : q;
    return m[AW-1:0];
  endfunction

  assign pitch_q = quant(a_pitch_r);
  assign roll_q  = quant(a_roll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_degen_r <= a_degen_r;
      o_pitch_r <= a_degen_r ? '0 : pitch_q;
      o_roll_r  <= a_degen_r ? '0 : roll_q;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {o_roll_r, o_pitch_r};
  assign out_tuser  = o_degen_r;

endmodule

FILE: tb/accel_tilt_pitch_roll_tb.sv
// Testbench for accel_tilt_pitch_roll: drives x/y/z samples on the input stream
// and checks pitch, roll and the degenerate flag against a CORDIC angle predictor.
// Depends on tpr_pkg and the accel_tilt_pitch_roll RTL.
module accel_tilt_pitch_roll_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = tpr_pkg::DEF_ANGLE_FRAC_BITS;
  localparam int LATENCY = 64;
  localparam int N_RANDOM = 480;

  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] roll;
    logic        degen;
  } angles_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               has_fixed;
    angles_t            fixed;
  } sample_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;    // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // pitch_angle [15:0], roll_angle [31:16]
  logic        out_tuser;   // degenerate [0]

  angles_t     angle_queue[$];
  int          mismatch_cnt;
  bit          no_stall;
  bit          inputs_done;
  sample_row_t sample_table[$];

  accel_tilt_pitch_roll dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // atan2(a, sqrt(b^2 + c^2)) in 2^-30 rad via vectoring CORDIC
  function automatic longint tilt_angle30(longint a, longint b, longint c);
    longint unsigned sq;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    longint xv;
    longint yv;
    longint dx;
    longint dy;
    longint ang;
    sq = longint'(b * b + c * c) << 30;
    rem = sq;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    xv = longint'(root);
    yv = a * 32768;
    ang = 0;
    for (int i = 0; i < tpr_pkg::CORDIC_STEPS; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx;
        yv -= dy;
        ang += longint'(tpr_pkg::ATAN_TAB[i]);
      end else begin
        xv -= dx;
        yv += dy;
        ang -= longint'(tpr_pkg::ATAN_TAB[i]);
      end
    end
    return ang;
  endfunction

  // Clamp negatives to zero, round 2^-30 rad to the output scale and wrap at a full turn
  function automatic logic [15:0] to_angle_code(longint v30);
    longint unsigned q;
    longint unsigned turn;
    int sh;
    sh = tpr_pkg::INT_ANGLE_BITS - FRAC;
    turn = (longint'(tpr_pkg::TWOPI30) + (64'd1 << (sh - 1))) >> sh;
    if (v30 < 0) v30 = 0;
    q = (longint'(v30) + (64'd1 << (sh - 1))) >> sh;
    return 16'(q % turn);
  endfunction

  function automatic angles_t predict_tilt(logic signed [15:0] x, logic signed [15:0] y,
                                           logic signed [15:0] z);
    angles_t r;
    longint xa;
    longint ya;
    longint p;
    longint q;
    r = '0;
    if (x == 0 && y == 0 && z == 0) begin
      r.degen = 1'b1;
      return r;
    end
    xa = tilt_angle30(x, y, z);
    ya = tilt_angle30(y, x, z);
    if (z >= 0 || (x == 0 && y == 0)) begin
      p = (xa < 0) ? xa + longint'(tpr_pkg::TWOPI30) : xa;
      q = (ya < 0) ? ya + longint'(tpr_pkg::TWOPI30) : ya;
    end else begin
      p = longint'(tpr_pkg::PI30) - xa;
      q = longint'(tpr_pkg::PI30) - ya;
    end
    r.pitch = to_angle_code(p);
    r.roll = to_angle_code(q);
    return r;
  endfunction

  function automatic sample_row_t mk_row(int x, int y, int z);
    sample_row_t r;
    r.x = 16'(x);
    r.y = 16'(y);
    r.z = 16'(z);
    r.has_fixed = 1'b0;
    r.fixed = '0;
    return r;
  endfunction

  // Send one sample and queue its expected angles on acceptance
  task automatic send_sample(sample_row_t r);
    angles_t exp_a;
    if (!no_stall && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    exp_a = r.has_fixed ? r.fixed : predict_tilt(r.x, r.y, r.z);
    in_tdata <= {r.z, r.y, r.x};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    angle_queue.push_back(exp_a);
    @(negedge clk);
  endtask

  // Output ready with random stall bursts
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!no_stall && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    angles_t got;
    angles_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tuser};
      if (angle_queue.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", got);
      end else begin
        want = angle_queue.pop_front();
        if (got.pitch !== want.pitch || got.roll !== want.roll ||
            got.degen !== want.degen) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: pitch exp %0d got %0d, roll exp %0d got %0d,",
                     want.pitch, got.pitch, want.roll, got.roll,
                     " degen exp %b got %b", want.degen, got.degen);
        end
      end
    end
  end

  // Stimulus
  initial begin
    sample_row_t r;
    int sel;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatch_cnt = 0;
    no_stall = 1'b0;
    inputs_done = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: all-zero sample, upright cases, extremes, zero horizontal magnitude
    r = mk_row(0, 0, 0);
    r.has_fixed = 1'b1;
    r.fixed = '{pitch: 16'd0, roll: 16'd0, degen: 1'b1};
    sample_table.push_back(r);
    r = mk_row(0, 0, 1000);
    r.has_fixed = 1'b1;
    r.fixed = '0;
    sample_table.push_back(r);
    r = mk_row(0, 0, 32767);
    r.has_fixed = 1'b1;
    r.fixed = '0;
    sample_table.push_back(r);
    sample_table.push_back(mk_row(0, 0, -32768));
    sample_table.push_back(mk_row(0, 0, -1));
    sample_table.push_back(mk_row(32767, 0, 0));
    sample_table.push_back(mk_row(-32768, 0, 0));
    sample_table.push_back(mk_row(0, 32767, 0));
    sample_table.push_back(mk_row(0, -32768, 0));
    sample_table.push_back(mk_row(32767, 32767, 32767));
    sample_table.push_back(mk_row(-32768, -32768, -32768));
    sample_table.push_back(mk_row(-32768, 32767, -32768));
    sample_table.push_back(mk_row(1, 1, -1));
    sample_table.push_back(mk_row(-1, -1, 1));
    sample_table.push_back(mk_row(-1, 0, 32767));
    sample_table.push_back(mk_row(0, -1, 32767));
    sample_table.push_back(mk_row(1000, -1000, -5));
    sample_table.push_back(mk_row(-1, -1, -32768));
    sample_table.push_back(mk_row(21845, -10922, 0));
    sample_table.push_back(mk_row(-5, 0, -1));
    foreach (sample_table[i]) send_sample(sample_table[i]);

    // Random: full range, small values, and samples with x or y near zero
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 80) no_stall = 1'b1;
      sel = $urandom_range(0, 3);
      case (sel)
        0: r = mk_row($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
        1: r = mk_row($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                      $urandom_range(0, 6) - 3);
        2: r = mk_row($urandom_range(0, 65535), $urandom_range(0, 8) - 4,
                      $urandom_range(0, 65535));
        default: r = mk_row($urandom_range(0, 8) - 4, $urandom_range(0, 65535),
                            $urandom_range(0, 65535));
      endcase
      send_sample(r);
    end
    in_tvalid <= 1'b0;
    inputs_done = 1'b1;
  end

  // End of run
  initial begin
    wait (inputs_done);
    wait (angle_queue.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_cnt == 0 && angle_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
sv/tpr_pkg.sv
sv/tpr_isqrt.sv
sv/tpr_cordic.sv
sv/accel_tilt_pitch_roll.sv
tb/accel_tilt_pitch_roll_tb.sv
